// ===== sv/ltc_pkg.sv =====
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types and constants of the LRU tag cache: field widths, result
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package ltc_pkg;

   localparam int ID_BITS       = 31;
   localparam int COUNT_BITS    = 32;
   localparam int STATUS_BITS   = 3;
   localparam int DEF_ENTRIES   = 16;
   localparam int DEF_DATA_BITS = 32;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_HIT      = 3'd0,
      ST_MISS     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_INSERTED = 3'd3,
      ST_DUP      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_READ,
      S_UPDATE
   } ctrl_state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic match;
      logic commit;
   } ltc_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic out_free;
   } ltc_stat_type;

endpackage

`default_nettype wire

// ===== sv/ltc_ram.sv =====
// ----------------------------------------------------------------------------
// ltc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/ltc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltc_ctrl
// Sequencer of the LRU tag cache: capture, tag compare, payload read and
// commit of one operation at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_ctrl
   import ltc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire ltc_stat_type stat,
   output ltc_cmd_type       cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            cmd.match = 1'b1;
            state_in  = S_READ;
         end
         S_READ: begin
            // payload read of the hit slot is in flight
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            // hold until the result register can take the transaction
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/ltc_datapath.sv =====
// ----------------------------------------------------------------------------
// ltc_datapath
// Tag store, recency ranks, payload RAM, counters and result register of
// the LRU tag cache.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_datapath
   import ltc_pkg::*;
#(
   parameter int ENTRIES   = DEF_ENTRIES,
   parameter int DATA_BITS = DEF_DATA_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ltc_cmd_type            cmd,
   output ltc_stat_type                stat,
   input  wire logic                   req_func,
   input  wire logic [ID_BITS-1:0]     req_key_id,
   input  wire logic [DATA_BITS-1:0]   req_entry_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [STATUS_BITS-1:0]      rsp_status,
   output logic [DATA_BITS-1:0]        rsp_hit_data,
   output logic                        rsp_evict_valid,
   output logic [ID_BITS-1:0]          rsp_evict_id,
   output logic [COUNT_BITS-1:0]       rsp_access_total,
   output logic [COUNT_BITS-1:0]       rsp_hit_total,
   output logic [COUNT_BITS-1:0]       rsp_miss_total
);

   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FILL_BITS = $clog2(ENTRIES + 1);

   // captured request
   logic                 func_ff, func_in;
   logic [ID_BITS-1:0]   key_ff, key_in;
   logic [DATA_BITS-1:0] data_ff, data_in;

   // compare results, one bit per slot
   logic [ENTRIES-1:0]   hit_ff, hit_in;
   logic [ENTRIES-1:0]   victim_ff, victim_in;

   // tag store and recency ranks, rank 0 is most recent
   logic [ID_BITS-1:0]   ids_ff  [ENTRIES];
   logic [ID_BITS-1:0]   ids_in  [ENTRIES];
   logic [IDX_BITS-1:0]  rank_ff [ENTRIES];
   logic [IDX_BITS-1:0]  rank_in [ENTRIES];
   logic [FILL_BITS-1:0] fill_ff, fill_in;

   logic [COUNT_BITS-1:0] access_ff, access_in;
   logic [COUNT_BITS-1:0] hits_ff, hits_in;
   logic [COUNT_BITS-1:0] misses_ff, misses_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [DATA_BITS-1:0]   hit_data_ff, hit_data_in;
   logic                   evict_valid_ff, evict_valid_in;
   logic [ID_BITS-1:0]     evict_id_ff, evict_id_in;

   // decode of the registered compare
   logic                 empty;
   logic                 found;
   logic                 full;
   logic                 insert_new;
   logic                 update;
   logic [IDX_BITS-1:0]  hit_idx;
   logic [IDX_BITS-1:0]  vic_idx;
   logic [IDX_BITS-1:0]  hit_rank;
   logic [ID_BITS-1:0]   vic_id;
   logic [ENTRIES-1:0]   slot_valid;
   logic [ENTRIES-1:0]   target;
   logic [ENTRIES-1:0]   age;
   status_type           status_code;

   logic                 ram_wr_en;
   logic [IDX_BITS-1:0]  ram_wr_addr;
   logic [DATA_BITS-1:0] ram_rd_data;

   ltc_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (ENTRIES)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (data_ff),
      .rd_addr (hit_idx),
      .rd_data (ram_rd_data)
   );

   // one-hot to index and selected fields; ids are unique, so at most one hit
   always_comb begin
      hit_idx  = '0;
      vic_idx  = '0;
      hit_rank = '0;
      vic_id   = '0;
      for (int j = 0; j < ENTRIES; j++) begin
         slot_valid[j] = FILL_BITS'(j) < fill_ff;
         if (hit_ff[j]) begin
            hit_idx  = hit_idx | IDX_BITS'(j);
            hit_rank = hit_rank | rank_ff[j];
         end
         if (victim_ff[j]) begin
            vic_idx = vic_idx | IDX_BITS'(j);
            vic_id  = vic_id | ids_ff[j];
         end
      end
   end

   always_comb begin
      empty      = fill_ff == '0;
      found      = |hit_ff;
      full       = fill_ff == FILL_BITS'(ENTRIES);
      insert_new = func_ff && !found;
      update     = cmd.commit && (found || insert_new);

      for (int j = 0; j < ENTRIES; j++) begin
         if (found) begin
            target[j] = hit_ff[j];
            age[j]    = rank_ff[j] < hit_rank;
         end else if (full) begin
            target[j] = victim_ff[j];
            age[j]    = rank_ff[j] != IDX_BITS'(ENTRIES - 1);
         end else begin
            target[j] = FILL_BITS'(j) == fill_ff;
            age[j]    = 1'b1;
         end
      end

      if (empty) begin
         status_code = ST_EMPTY;
      end else if (found) begin
         status_code = ST_HIT;
      end else begin
         status_code = ST_MISS;
      end
      if (func_ff) begin
         status_code = found ? ST_DUP : ST_INSERTED;
      end

      ram_wr_en   = cmd.commit && insert_new;
      ram_wr_addr = full ? vic_idx : fill_ff[IDX_BITS-1:0];
   end

   always_comb begin
      func_in        = func_ff;
      key_in         = key_ff;
      data_in        = data_ff;
      hit_in         = hit_ff;
      victim_in      = victim_ff;
      ids_in         = ids_ff;
      rank_in        = rank_ff;
      fill_in        = fill_ff;
      access_in      = access_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      status_in      = status_ff;
      hit_data_in    = hit_data_ff;
      evict_valid_in = evict_valid_ff;
      evict_id_in    = evict_id_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (cmd.load) begin
         func_in = req_func;
         key_in  = req_key_id;
         data_in = req_entry_data;
      end

      if (cmd.match) begin
         for (int j = 0; j < ENTRIES; j++) begin
            hit_in[j]    = slot_valid[j] && (ids_ff[j] == key_ff);
            victim_in[j] = rank_ff[j] == IDX_BITS'(ENTRIES - 1);
         end
      end

      if (update) begin
         for (int j = 0; j < ENTRIES; j++) begin
            if (target[j]) begin
               rank_in[j] = '0;
               if (insert_new) begin
                  ids_in[j] = key_ff;
               end
            end else if (slot_valid[j] && age[j]) begin
               rank_in[j] = rank_ff[j] + IDX_BITS'(1);
            end
         end
         if (insert_new && !full) begin
            fill_in = fill_ff + FILL_BITS'(1);
         end
      end

      if (cmd.commit) begin
         if (!empty) begin
            access_in = access_ff + COUNT_BITS'(1);
            if (found) begin
               hits_in = hits_ff + COUNT_BITS'(1);
            end else begin
               misses_in = misses_ff + COUNT_BITS'(1);
            end
         end
         rsp_valid_in   = 1'b1;
         status_in      = status_code;
         hit_data_in    = found ? ram_rd_data : '0;
         evict_valid_in = insert_new && full;
         evict_id_in    = (insert_new && full) ? vic_id : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         access_ff    <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         access_ff    <= access_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      key_ff         <= key_in;
      data_ff        <= data_in;
      hit_ff         <= hit_in;
      victim_ff      <= victim_in;
      ids_ff         <= ids_in;
      rank_ff        <= rank_in;
      status_ff      <= status_in;
      hit_data_ff    <= hit_data_in;
      evict_valid_ff <= evict_valid_in;
      evict_id_ff    <= evict_id_in;
   end

   assign stat.out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_hit_data     = hit_data_ff;
   assign rsp_evict_valid  = evict_valid_ff;
   assign rsp_evict_id     = evict_id_ff;
   assign rsp_access_total = access_ff;
   assign rsp_hit_total    = hits_ff;
   assign rsp_miss_total   = misses_ff;

endmodule

`default_nettype wire

// ===== sv/lru_tag_cache.sv =====
// ----------------------------------------------------------------------------
// lru_tag_cache
// Fully associative LRU store of id-keyed entries with lookup and insert
// operations, eviction reporting and running access, hit and miss counts.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    func, key_id, entry_data
//   rsp_      out         rsp_valid/rsp_ready    status, hit_data, evict_valid,
//                                                evict_id, access/hit/miss totals
//
// An operation passes through capture, tag compare over all slots, registered
// read of the payload RAM, and commit of ranks, tags and counters; the result
// register loads at commit. One operation is in flight at a time, and no new
// request is taken before the previous one commits.
// Reset clears the fill count, the counters and the result valid; no
// clearing pass runs, the cache is ready in the first cycle after reset.
// A stalled result holds the commit stage; the next request is taken while
// the finished result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_tag_cache
   import ltc_pkg::*;
#(
   parameter int ENTRIES   = DEF_ENTRIES,
   parameter int DATA_BITS = DEF_DATA_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_func,
   input  wire logic [ID_BITS-1:0]     req_key_id,
   input  wire logic [DATA_BITS-1:0]   req_entry_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [STATUS_BITS-1:0]      rsp_status,
   output logic [DATA_BITS-1:0]        rsp_hit_data,
   output logic                        rsp_evict_valid,
   output logic [ID_BITS-1:0]          rsp_evict_id,
   output logic [COUNT_BITS-1:0]       rsp_access_total,
   output logic [COUNT_BITS-1:0]       rsp_hit_total,
   output logic [COUNT_BITS-1:0]       rsp_miss_total
);

   ltc_cmd_type  cmd;
   ltc_stat_type stat;

   ltc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ltc_datapath #(
      .ENTRIES   (ENTRIES),
      .DATA_BITS (DATA_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_func),
      .req_key_id       (req_key_id),
      .req_entry_data   (req_entry_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_hit_data     (rsp_hit_data),
      .rsp_evict_valid  (rsp_evict_valid),
      .rsp_evict_id     (rsp_evict_id),
      .rsp_access_total (rsp_access_total),
      .rsp_hit_total    (rsp_hit_total),
      .rsp_miss_total   (rsp_miss_total)
   );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LRU tag cache. A behavioural copy of the store
// (ids, payloads, recency ranks, fill count and running counters) predicts
// every result. Directed tests cover the empty store, hits, duplicate
// inserts and eviction from a full store. Random traffic then draws ids from
// pools of several sizes so that hits, duplicates and eviction churn all
// occur, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module tb;
   import ltc_pkg::*;

   localparam int ENTRIES   = DEF_ENTRIES;
   localparam int DATA_BITS = DEF_DATA_BITS;
   localparam int POOL_MAX  = 48;

   typedef struct packed {
      status_type              status;
      logic [DATA_BITS-1:0]    hit_data;
      logic                    evict_valid;
      logic [ID_BITS-1:0]      evict_id;
      logic [COUNT_BITS-1:0]   access_total;
      logic [COUNT_BITS-1:0]   hit_total;
      logic [COUNT_BITS-1:0]   miss_total;
   } cache_result_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_func;
   logic [ID_BITS-1:0]      req_key_id;
   logic [DATA_BITS-1:0]    req_entry_data;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [STATUS_BITS-1:0]  rsp_status;
   logic [DATA_BITS-1:0]    rsp_hit_data;
   logic                    rsp_evict_valid;
   logic [ID_BITS-1:0]      rsp_evict_id;
   logic [COUNT_BITS-1:0]   rsp_access_total;
   logic [COUNT_BITS-1:0]   rsp_hit_total;
   logic [COUNT_BITS-1:0]   rsp_miss_total;

   lru_tag_cache #(
      .ENTRIES   (ENTRIES),
      .DATA_BITS (DATA_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_key_id       (req_key_id),
      .req_entry_data   (req_entry_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_hit_data     (rsp_hit_data),
      .rsp_evict_valid  (rsp_evict_valid),
      .rsp_evict_id     (rsp_evict_id),
      .rsp_access_total (rsp_access_total),
      .rsp_hit_total    (rsp_hit_total),
      .rsp_miss_total   (rsp_miss_total)
   );

   // shadow copy of the cache
   logic [ID_BITS-1:0]      cache_ids      [ENTRIES];
   logic [DATA_BITS-1:0]    cache_payloads [ENTRIES];
   logic [3:0]              cache_rank     [ENTRIES];
   int                      cache_fill;
   logic [COUNT_BITS-1:0]   count_access;
   logic [COUNT_BITS-1:0]   count_hits;
   logic [COUNT_BITS-1:0]   count_misses;

   cache_result_type        lookup_results_due[$];
   logic [ID_BITS-1:0]      id_pool[POOL_MAX];

   int  error_count;
   int  n_lookups;
   int  n_inserts;
   int  n_evictions;
   int  n_duplicates;
   int  n_hits;
   bit  sender_idle;
   bit  receiver_stall;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: done, errors");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // slots more recent than s age by one, s becomes most recent
   function automatic void make_most_recent(int s);
      logic [3:0] old_rank;
      old_rank = cache_rank[s];
      for (int j = 0; j < cache_fill; j++) begin
         if (cache_rank[j] < old_rank) cache_rank[j]++;
      end
      cache_rank[s] = 4'd0;
   endfunction

   function automatic cache_result_type apply_cache_op(logic func, logic [ID_BITS-1:0] key,
                                                       logic [DATA_BITS-1:0] data);
      cache_result_type r;
      bit               found;
      int               slot;
      int               victim;
      r        = '0;
      r.status = ST_EMPTY;
      found    = 1'b0;
      slot     = 0;
      victim   = 0;
      if (func) n_inserts++;
      else n_lookups++;
      if (cache_fill != 0) begin
         count_access++;
         for (int j = 0; j < cache_fill; j++) begin
            if (!found && cache_ids[j] == key) begin
               found = 1'b1;
               slot  = j;
            end
         end
         if (found) begin
            count_hits++;
            n_hits++;
            make_most_recent(slot);
            r.hit_data = cache_payloads[slot];
            r.status   = ST_HIT;
         end else begin
            count_misses++;
            r.status = ST_MISS;
         end
      end
      if (func) begin
         if (found) begin
            r.status = ST_DUP;
            n_duplicates++;
         end else begin
            if (cache_fill >= ENTRIES) begin
               for (int j = ENTRIES - 1; j >= 0; j--) begin
                  if (cache_rank[j] == ENTRIES - 1) victim = j;
               end
               r.evict_valid          = 1'b1;
               r.evict_id             = cache_ids[victim];
               cache_ids[victim]      = key;
               cache_payloads[victim] = data;
               make_most_recent(victim);
               n_evictions++;
            end else begin
               for (int j = 0; j < cache_fill; j++) cache_rank[j]++;
               cache_ids[cache_fill]      = key;
               cache_payloads[cache_fill] = data;
               cache_rank[cache_fill]     = 4'd0;
               cache_fill++;
            end
            r.status = ST_INSERTED;
         end
      end
      r.access_total = count_access;
      r.hit_total    = count_hits;
      r.miss_total   = count_misses;
      return r;
   endfunction

   // one transaction on the request side; valid stays up when no gap follows
   task automatic send_op(input logic func, input logic [ID_BITS-1:0] key,
                          input logic [DATA_BITS-1:0] data);
      int gap;
      gap = sender_idle ? gap_cycles() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_key_id     <= key;
      req_entry_data <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      lookup_results_due.push_back(apply_cache_op(func, key, data));
   endtask

   // result side: random stall runs
   initial begin : rsp_sink
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (receiver_stall && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_cycles() + 1) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      cache_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (lookup_results_due.size() == 0) begin
            $error("unexpected result transaction, status %0d", rsp_status);
            error_count++;
         end else begin
            exp_r = lookup_results_due.pop_front();
            if (rsp_status !== exp_r.status) begin
               $error("status: expected %0d, got %0d", exp_r.status, rsp_status);
               error_count++;
            end
            if (rsp_hit_data !== exp_r.hit_data) begin
               $error("hit_data: expected %h, got %h", exp_r.hit_data, rsp_hit_data);
               error_count++;
            end
            if (rsp_evict_valid !== exp_r.evict_valid) begin
               $error("evict_valid: expected %b, got %b", exp_r.evict_valid,
                      rsp_evict_valid);
               error_count++;
            end
            if (rsp_evict_id !== exp_r.evict_id) begin
               $error("evict_id: expected %h, got %h", exp_r.evict_id, rsp_evict_id);
               error_count++;
            end
            if (rsp_access_total !== exp_r.access_total) begin
               $error("access_total: expected %0d, got %0d", exp_r.access_total,
                      rsp_access_total);
               error_count++;
            end
            if (rsp_hit_total !== exp_r.hit_total) begin
               $error("hit_total: expected %0d, got %0d", exp_r.hit_total, rsp_hit_total);
               error_count++;
            end
            if (rsp_miss_total !== exp_r.miss_total) begin
               $error("miss_total: expected %0d, got %0d", exp_r.miss_total,
                      rsp_miss_total);
               error_count++;
            end
         end
      end
   end

   // lookups on an empty store count nothing; an insert then fills slot 0
   task automatic test_empty_store();
      send_op(1'b0, {ID_BITS{1'b1}}, {DATA_BITS{1'b1}});
      send_op(1'b0, '0, '0);
      send_op(1'b1, {ID_BITS{1'b1}}, {DATA_BITS{1'b1}});
   endtask

   task automatic test_hit_and_duplicate();
      send_op(1'b1, '0, '0);
      send_op(1'b0, {ID_BITS{1'b1}}, '0);
      send_op(1'b0, 31'h2AAA_AAAA, 32'h5555_5555);
      // duplicate insert keeps the stored payload
      send_op(1'b1, '0, 32'hDEAD_BEEF);
      send_op(1'b0, '0, {DATA_BITS{1'b1}});
   endtask

   task automatic test_fill_and_evict();
      for (int k = 0; k < ENTRIES - 2; k++) begin
         send_op(1'b1, 31'h2AAA_0000 | ID_BITS'(k), ~DATA_BITS'(k));
      end
      // the all-ones id is now least recent and goes out
      send_op(1'b1, 31'h5555_5555, 32'hA5A5_5A5A);
      send_op(1'b0, {ID_BITS{1'b1}}, '0);
      send_op(1'b0, 31'h5555_5555, '0);
   endtask

   task automatic test_random_traffic(input int n_items, input int pool_size,
                                      input bit with_idle);
      logic [ID_BITS-1:0] key;
      sender_idle    = with_idle;
      receiver_stall = with_idle;
      for (int k = 0; k < pool_size; k++) id_pool[k] = ID_BITS'($urandom());
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 9) < 8) key = id_pool[$urandom_range(0, pool_size - 1)];
         else key = ID_BITS'($urandom());
         send_op(1'($urandom_range(0, 1)), key, DATA_BITS'($urandom()));
      end
   endtask

   initial begin
      int waited;
      error_count    = 0;
      n_lookups      = 0;
      n_inserts      = 0;
      n_evictions    = 0;
      n_duplicates   = 0;
      n_hits         = 0;
      cache_fill     = 0;
      count_access   = '0;
      count_hits     = '0;
      count_misses   = '0;
      sender_idle    = 1'b1;
      receiver_stall = 1'b1;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_func       <= 1'b0;
      req_key_id     <= '0;
      req_entry_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_store();
      test_hit_and_duplicate();
      test_fill_and_evict();
      test_random_traffic(400, 12, 1'b0);
      test_random_traffic(500, 24, 1'b1);
      test_random_traffic(450, POOL_MAX, 1'b1);
      req_valid <= 1'b0;

      waited = 0;
      while (lookup_results_due.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (lookup_results_due.size() != 0) begin
         $error("%0d result transactions never arrived", lookup_results_due.size());
         error_count++;
      end
      repeat (12) @(posedge clock);

      $display("tb: %0d lookups and %0d inserts, %0d hits, %0d duplicate inserts",
               n_lookups, n_inserts, n_hits, n_duplicates);
      $display("tb: %0d evictions from a full store, %0d mismatches", n_evictions,
               error_count);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
